// ----- rtl/core/upr_pkg.sv -----
package upr_pkg;

    localparam int unsigned START_TIMEOUT_US_DEF = 18000;
    localparam int unsigned US_PER_CM_DEF        = 57;

    localparam int unsigned MAX_DIST_W   = 9;
    localparam int unsigned TIME_W       = 15;
    localparam int unsigned TICK_W       = 16;
    localparam int unsigned ELAPSED_W    = TICK_W + 1;

    localparam logic [MAX_DIST_W-1:0] MAX_DIST_RESET = 9'd70;

    localparam int unsigned TRIG_LOW_TICKS  = 4;
    localparam int unsigned TRIG_HIGH_TICKS = 10;
    localparam int unsigned ECHO_OVERHEAD   = 5;

    // reciprocal divide: exact floor(n/d) for n < 2**DIV_IN_W, 2**(DIV_SHIFT-RECIP_W) < d <= 2**DIV_LOG_D
    localparam int unsigned DIV_IN_W    = 16;
    localparam int unsigned DIV_LOG_D   = 7;
    localparam int unsigned DIV_SHIFT   = DIV_IN_W + DIV_LOG_D;
    localparam int unsigned RECIP_W     = 18;
    localparam int unsigned DIV_PROD_W  = DIV_IN_W + RECIP_W;

    typedef struct packed {
        logic                       trigger;
        logic                       busy;
        logic                       done;
        logic                       no_echo;
        logic [TIME_W-1:0]          echo_time;
        logic [MAX_DIST_W-1:0]      distance;
    } result_t;

endpackage

// ----- rtl/core/upr_dist.sv -----
module upr_dist #(
    parameter int unsigned US_PER_CM = upr_pkg::US_PER_CM_DEF
) (
    input  logic [upr_pkg::TIME_W-1:0]     echo_time,
    output logic [upr_pkg::MAX_DIST_W-1:0] distance
);

    localparam int unsigned RECIP_MUL = ((2 ** upr_pkg::DIV_SHIFT) + US_PER_CM - 1) / US_PER_CM;

    logic [upr_pkg::DIV_IN_W-1:0]   rounded;
    logic [upr_pkg::DIV_PROD_W-1:0] prod;
    logic [upr_pkg::DIV_PROD_W-upr_pkg::DIV_SHIFT-1:0] quot;

    // (t + d/2) / d via multiply by rounded-up reciprocal
    assign rounded = upr_pkg::DIV_IN_W'(echo_time) + upr_pkg::DIV_IN_W'(US_PER_CM / 2);
    assign prod    = upr_pkg::DIV_PROD_W'(rounded) *
                     upr_pkg::DIV_PROD_W'(upr_pkg::RECIP_W'(RECIP_MUL));
    assign quot    = prod[upr_pkg::DIV_PROD_W-1:upr_pkg::DIV_SHIFT];

    always_comb
    begin
        if ((quot == '0) && (echo_time != '0))
        begin
            distance = upr_pkg::MAX_DIST_W'(1);
        end
        else
        begin
            distance = quot[upr_pkg::MAX_DIST_W-1:0];
        end
    end

endmodule

// ----- rtl/core/upr_seq.sv -----
module upr_seq #(
    parameter int unsigned START_TIMEOUT_US = upr_pkg::START_TIMEOUT_US_DEF,
    parameter int unsigned US_PER_CM        = upr_pkg::US_PER_CM_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic                         start,
    input  logic                         echo,
    input  logic [upr_pkg::TICK_W-1:0]   echo_max,
    output upr_pkg::result_t             result
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_TLOW   = 3'd1;
    localparam logic [2:0] PH_THIGH  = 3'd2;
    localparam logic [2:0] PH_WCLEAR = 3'd3;
    localparam logic [2:0] PH_WRISE  = 3'd4;
    localparam logic [2:0] PH_ECHO   = 3'd5;

    localparam logic [upr_pkg::ELAPSED_W-1:0] START_LIMIT = upr_pkg::ELAPSED_W'(START_TIMEOUT_US);

    logic [2:0]                       phase_reg, phase_next;
    logic [upr_pkg::TICK_W-1:0]       tick_reg, tick_next;
    logic [upr_pkg::TIME_W-1:0]       last_time_reg, last_time_next;
    logic [upr_pkg::MAX_DIST_W-1:0]   last_dist_reg, last_dist_next;

    logic [upr_pkg::ELAPSED_W-1:0]    elapsed;
    logic [upr_pkg::TIME_W-1:0]       pulse_time;
    logic [upr_pkg::MAX_DIST_W-1:0]   pulse_dist;
    logic                             finish;
    logic                             timed_out;

    assign elapsed = upr_pkg::ELAPSED_W'(tick_reg) + upr_pkg::ELAPSED_W'(1);

    // pulse time less overhead, floored at zero
    always_comb
    begin
        if (elapsed > upr_pkg::ELAPSED_W'(upr_pkg::ECHO_OVERHEAD))
        begin
            pulse_time = upr_pkg::TIME_W'(elapsed - upr_pkg::ELAPSED_W'(upr_pkg::ECHO_OVERHEAD));
        end
        else
        begin
            pulse_time = '0;
        end
    end

    upr_dist #(
        .US_PER_CM (US_PER_CM)
    ) u_dist (
        .echo_time (pulse_time),
        .distance  (pulse_dist)
    );

    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        finish         = 1'b0;
        timed_out      = 1'b0;
        result.trigger = 1'b0;
        result.busy    = 1'b1;

        unique case (phase_reg) inside
            PH_TLOW:
            begin
                tick_next = elapsed[upr_pkg::TICK_W-1:0];
                if (elapsed >= upr_pkg::ELAPSED_W'(upr_pkg::TRIG_LOW_TICKS))
                begin
                    phase_next = PH_THIGH;
                    tick_next  = '0;
                end
            end
            PH_THIGH:
            begin
                result.trigger = 1'b1;
                tick_next      = elapsed[upr_pkg::TICK_W-1:0];
                if (elapsed >= upr_pkg::ELAPSED_W'(upr_pkg::TRIG_HIGH_TICKS))
                begin
                    phase_next = PH_WCLEAR;
                    tick_next  = '0;
                end
            end
            PH_WCLEAR, PH_WRISE:
            begin
                if (echo)
                begin
                    // echo high: in WCLEAR wait for it to clear, else the rise
                    if ((phase_reg == PH_WCLEAR) && (elapsed <= START_LIMIT))
                    begin
                        tick_next = elapsed[upr_pkg::TICK_W-1:0];
                    end
                    else
                    begin
                        phase_next = PH_ECHO;
                        tick_next  = '0;
                    end
                end
                else if (elapsed > START_LIMIT)
                begin
                    finish    = 1'b1;
                    timed_out = 1'b1;
                end
                else
                begin
                    phase_next = PH_WRISE;
                    tick_next  = elapsed[upr_pkg::TICK_W-1:0];
                end
            end
            PH_ECHO:
            begin
                if (echo)
                begin
                    if (elapsed > upr_pkg::ELAPSED_W'(echo_max))
                    begin
                        finish    = 1'b1;
                        timed_out = 1'b1;
                    end
                    else
                    begin
                        tick_next = elapsed[upr_pkg::TICK_W-1:0];
                    end
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (start)
                begin
                    phase_next = PH_TLOW;
                    tick_next  = upr_pkg::TICK_W'(1);
                end
                else
                begin
                    tick_next   = '0;
                    result.busy = 1'b0;
                end
            end
        endcase

        last_time_next = last_time_reg;
        last_dist_next = last_dist_reg;
        if (finish)
        begin
            phase_next  = PH_IDLE;
            tick_next   = '0;
            result.busy = 1'b0;
            if (timed_out)
            begin
                last_time_next = '0;
                last_dist_next = '0;
            end
            else
            begin
                last_time_next = pulse_time;
                last_dist_next = pulse_dist;
            end
        end

        result.done      = finish;
        result.no_echo   = timed_out;
        result.echo_time = last_time_next;
        result.distance  = last_dist_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            last_time_reg <= '0;
            last_dist_reg <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            last_time_reg <= last_time_next;
            last_dist_reg <= last_dist_next;
        end
    end

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.done) |=> (phase_reg == PH_IDLE) && (tick_reg == '0))
        else $error("phase not idle after a result");

    a_trigger_from_high: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (phase_reg == PH_TLOW) && (phase_next == PH_THIGH)) |=>
            (tick_reg == '0) && result.trigger)
        else $error("trigger pulse did not start after low phase");

    a_hold_when_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(tick_reg) && $stable(last_time_reg))
        else $error("state moved without an accepted word");

endmodule

// ----- rtl/core/ultrasonic_ping_ranger_core.sv -----
// Ultrasonic ping ranger core.
// Input channel: one word per microsecond tick with start_req and the sampled
// echo_level. Output channel: one word per input word with trigger_level (to
// drive on the sensor pin), busy_res, done_res, no_echo and the last result's
// echo_time_us and distance_cm (held between results, 0 after a timeout).
// A start while busy is ignored. max_distance_cm (cfg_wr_en/cfg_wr_data) sets
// the echo timeout to max_distance_cm*US_PER_CM + US_PER_CM/2 ticks; write it
// only while no ping is running.
// Path: a word accepted into the input register passes once through the
// sequencer and the reciprocal divider into the output register when the
// output is free, and out_valid rises with the output register load.
// Throughput is one word per cycle while out_stall is low.
// When out_stall is held, the output word holds and the input register
// fills; in_stall then rises until the output is taken.
// Reset clears both valid flags, puts the sequencer in idle with a zero time
// and distance, and loads max_distance_cm with 70.
module ultrasonic_ping_ranger_core #(
    parameter int unsigned START_TIMEOUT_US = upr_pkg::START_TIMEOUT_US_DEF,
    parameter int unsigned US_PER_CM        = upr_pkg::US_PER_CM_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_wr_en,
    input  logic [upr_pkg::MAX_DIST_W-1:0]   cfg_wr_data,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             start_req,
    input  logic                             echo_level,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             trigger_level,
    output logic                             busy_res,
    output logic                             done_res,
    output logic                             no_echo,
    output logic [upr_pkg::TIME_W-1:0]       echo_time_us,
    output logic [upr_pkg::MAX_DIST_W-1:0]   distance_cm
);

    logic [upr_pkg::MAX_DIST_W-1:0] max_dist_reg;
    logic [upr_pkg::TICK_W-1:0]     echo_max;

    logic                           in_valid_reg;
    logic                           start_reg;
    logic                           echo_reg;
    logic                           out_valid_reg;
    upr_pkg::result_t               out_reg;
    upr_pkg::result_t               result;
    logic                           step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg <= upr_pkg::MAX_DIST_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_dist_reg <= cfg_wr_data;
        end
    end

    assign echo_max = upr_pkg::TICK_W'(max_dist_reg) * upr_pkg::TICK_W'(US_PER_CM) +
                      upr_pkg::TICK_W'(US_PER_CM / 2);

    assign step     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            start_reg <= start_req;
            echo_reg  <= echo_level;
        end
    end

    upr_seq #(
        .START_TIMEOUT_US (START_TIMEOUT_US),
        .US_PER_CM        (US_PER_CM)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .start    (start_reg),
        .echo     (echo_reg),
        .echo_max (echo_max),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign trigger_level = out_reg.trigger;
    assign busy_res      = out_reg.busy;
    assign done_res      = out_reg.done;
    assign no_echo       = out_reg.no_echo;
    assign echo_time_us  = out_reg.echo_time;
    assign distance_cm   = out_reg.distance;

    a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_echo) |-> (done_res && !busy_res &&
            (echo_time_us == '0) && (distance_cm == '0)))
        else $error("timeout word with nonzero result");

    a_min_distance: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (echo_time_us != '0)) |-> (distance_cm != '0))
        else $error("nonzero echo time with zero distance");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid && out_stall))
        else $error("input stalled while output can move");

endmodule

// ----- tb/sv/ultrasonic_ping_ranger_core_tb.sv -----
`timescale 1ns / 1ps

module ultrasonic_ping_ranger_core_tb;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned HALF_CM     = upr_pkg::US_PER_CM_DEF / 2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TRIG_LOW,
        PH_TRIG_HIGH,
        PH_WAIT_CLEAR,
        PH_WAIT_RISE,
        PH_ECHO
    } ping_phase_t;

    // one tick word; known marks a done tick whose result is typed in
    typedef struct {
        bit          start;
        bit          echo;
        bit          known;
        bit          exp_no_echo;
        int unsigned exp_time;
        int unsigned exp_dist;
    } tick_word_t;

    typedef struct {
        int cfg;        // -1: keep the current max distance
        int clear;      // echo high ticks before it clears
        int gap;        // echo low ticks before the rise
        int pulse;      // echo high ticks, 0 for none
        int known;
        int no_echo;
        int time_us;
        int dist_cm;
    } ping_row_t;

    ping_row_t directed_pings [11] = '{
        //  cfg  clear   gap  pulse  known ne   time  dist
        '{   -1,     0,     1,     1,   1,  0,     0,    0},  // pulse under overhead
        '{   -1,     2,     3,     6,   1,  0,     1,    1},  // tiny time rounds up to 1 cm
        '{   -1,     0,     1,    33,   1,  0,    28,    1},
        '{   -1,     0,     5,    34,   1,  0,    29,    1},
        '{   -1,     1,     1,    62,   0,  0,     0,    0},
        '{    1,     0,     1,    86,   1,  0,    81,    1},  // longest pulse in window
        '{   -1,     0,     1,    87,   1,  1,     0,    0},  // echo too long
        '{    0,     0,     1,    29,   1,  0,    24,    1},
        '{   -1,     0,     1,    30,   1,  1,     0,    0},
        '{  511,     0,     1,    40,   0,  0,     0,    0},
        '{  500,     0,     3,    20,   0,  0,     0,    0}
    };

    logic                           clk;
    logic                           rst_n       = 1'b0;
    logic                           cfg_wr_en   = 1'b0;
    logic [upr_pkg::MAX_DIST_W-1:0] cfg_wr_data = '0;
    logic                           in_valid    = 1'b0;
    logic                           in_stall;
    logic                           start_req   = 1'b0;
    logic                           echo_level  = 1'b0;
    logic                           out_valid;
    logic                           out_stall   = 1'b0;
    logic                           trigger_level;
    logic                           busy_res;
    logic                           done_res;
    logic                           no_echo;
    logic [upr_pkg::TIME_W-1:0]     echo_time_us;
    logic [upr_pkg::MAX_DIST_W-1:0] distance_cm;

    tick_word_t        tick_q[$];
    upr_pkg::result_t  pending_results[$];
    tick_word_t        cur_word;
    int unsigned       words_built  = 0;
    int unsigned       mismatches   = 0;
    int unsigned       cycles       = 0;
    int unsigned       in_idle_pct  = 0;
    int unsigned       out_stall_pct = 0;

    // predictor state
    ping_phase_t                    ping_phase   = PH_IDLE;
    int unsigned                    tick_cnt     = 0;
    int unsigned                    last_time    = 0;
    int unsigned                    last_dist    = 0;
    logic [upr_pkg::MAX_DIST_W-1:0] max_dist_cfg = upr_pkg::MAX_DIST_RESET;

    ultrasonic_ping_ranger_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .start_req     (start_req),
        .echo_level    (echo_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .trigger_level (trigger_level),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .no_echo       (no_echo),
        .echo_time_us  (echo_time_us),
        .distance_cm   (distance_cm)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned echo_window();
        return max_dist_cfg * upr_pkg::US_PER_CM_DEF + HALF_CM;
    endfunction

    task automatic predict_ranger_tick(input tick_word_t w);
        upr_pkg::result_t r;
        int unsigned      elapsed;
        int unsigned      t;
        int unsigned      d;
        bit               finished;
        bit               timed_out;
        elapsed   = tick_cnt + 1;
        r         = '0;
        r.busy    = 1'b1;
        finished  = 1'b0;
        timed_out = 1'b0;
        case (ping_phase) inside
            PH_TRIG_LOW:
            begin
                tick_cnt = elapsed;
                if (tick_cnt >= upr_pkg::TRIG_LOW_TICKS)
                begin
                    ping_phase = PH_TRIG_HIGH;
                    tick_cnt   = 0;
                end
            end
            PH_TRIG_HIGH:
            begin
                r.trigger = 1'b1;
                tick_cnt  = elapsed;
                if (tick_cnt >= upr_pkg::TRIG_HIGH_TICKS)
                begin
                    ping_phase = PH_WAIT_CLEAR;
                    tick_cnt   = 0;
                end
            end
            PH_WAIT_CLEAR, PH_WAIT_RISE:
            begin
                if (w.echo)
                begin
                    if (ping_phase == PH_WAIT_CLEAR &&
                        elapsed <= upr_pkg::START_TIMEOUT_US_DEF)
                        tick_cnt = elapsed;
                    else
                    begin
                        // a stuck-high echo counts as the rise
                        ping_phase = PH_ECHO;
                        tick_cnt   = 0;
                    end
                end
                else if (elapsed > upr_pkg::START_TIMEOUT_US_DEF)
                begin
                    finished  = 1'b1;
                    timed_out = 1'b1;
                end
                else
                begin
                    ping_phase = PH_WAIT_RISE;
                    tick_cnt   = elapsed;
                end
            end
            PH_ECHO:
            begin
                if (!w.echo)
                    finished = 1'b1;
                else if (elapsed > echo_window())
                begin
                    finished  = 1'b1;
                    timed_out = 1'b1;
                end
                else
                    tick_cnt = elapsed & 32'hFFFF;
            end
            default:
            begin
                if (w.start)
                begin
                    ping_phase = PH_TRIG_LOW;
                    tick_cnt   = 1;
                end
                else
                begin
                    ping_phase = PH_IDLE;
                    tick_cnt   = 0;
                    r.busy     = 1'b0;
                end
            end
        endcase
        if (finished)
        begin
            t = 0;
            d = 0;
            if (!timed_out)
            begin
                t = (elapsed > upr_pkg::ECHO_OVERHEAD) ? elapsed - upr_pkg::ECHO_OVERHEAD : 0;
                t = t & 32'h7FFF;
                d = (t + HALF_CM) / upr_pkg::US_PER_CM_DEF;
                if (t != 0 && d == 0)
                    d = 1;
                d = d & 32'h1FF;
            end
            last_time  = t;
            last_dist  = d;
            ping_phase = PH_IDLE;
            tick_cnt   = 0;
            r.busy     = 1'b0;
            r.done     = 1'b1;
            r.no_echo  = timed_out;
        end
        r.echo_time = last_time[upr_pkg::TIME_W-1:0];
        r.distance  = last_dist[upr_pkg::MAX_DIST_W-1:0];
        if (w.known)
        begin
            r.trigger   = 1'b0;
            r.busy      = 1'b0;
            r.done      = 1'b1;
            r.no_echo   = w.exp_no_echo;
            r.echo_time = w.exp_time[upr_pkg::TIME_W-1:0];
            r.distance  = w.exp_dist[upr_pkg::MAX_DIST_W-1:0];
        end
        pending_results.push_back(r);
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                predict_ranger_tick(cur_word);
            if (!in_valid || !in_stall)
            begin
                if (tick_q.size() != 0 && $urandom_range(99) >= in_idle_pct)
                begin
                    cur_word = tick_q.pop_front();
                    in_valid   <= 1'b1;
                    start_req  <= cur_word.start;
                    echo_level <= cur_word.echo;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                     act_v);
            mismatches++;
        end
    endtask

    // receiver
    always @(posedge clk)
    begin
        upr_pkg::result_t exp_r;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: word with nothing expected, actual time %0d dist %0d",
                             $time, echo_time_us, distance_cm);
                    mismatches++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    check_field("trigger_level", 16'(exp_r.trigger), 16'(trigger_level));
                    check_field("busy_res", 16'(exp_r.busy), 16'(busy_res));
                    check_field("done_res", 16'(exp_r.done), 16'(done_res));
                    check_field("no_echo", 16'(exp_r.no_echo), 16'(no_echo));
                    check_field("echo_time_us", 16'(exp_r.echo_time), 16'(echo_time_us));
                    check_field("distance_cm", 16'(exp_r.distance), 16'(distance_cm));
                end
            end
            out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_tick(input bit start, input bit echo);
        tick_word_t w;
        w       = '{default: 0};
        w.start = start;
        w.echo  = echo;
        tick_q.push_back(w);
        words_built++;
    endtask

    task automatic queue_ping(input int lead, input int clear, input int gap, input int pulse,
                              input int unsigned busy_start_pct);
        int unsigned win;
        int          highs;
        bit          cut;
        win = echo_window();
        repeat (lead) push_tick(1'b0, 1'($urandom_range(1)));
        push_tick(1'b1, 1'($urandom_range(1)));
        repeat (upr_pkg::TRIG_LOW_TICKS - 1 + upr_pkg::TRIG_HIGH_TICKS)
            push_tick($urandom_range(99) < busy_start_pct, 1'($urandom_range(1)));
        repeat (clear) push_tick($urandom_range(99) < busy_start_pct, 1'b1);
        repeat (gap) push_tick($urandom_range(99) < busy_start_pct, 1'b0);
        if (pulse > 0)
        begin
            // past the window the block times out on the last high tick
            cut   = pulse > win + 1;
            highs = cut ? win + 2 : pulse;
            repeat (highs) push_tick($urandom_range(99) < busy_start_pct, 1'b1);
            if (!cut)
                push_tick($urandom_range(99) < busy_start_pct, 1'b0);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (tick_q.size() != 0 || in_valid || pending_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_max_distance(input int unsigned value);
        wait_drained();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[upr_pkg::MAX_DIST_W-1:0];
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        max_dist_cfg = value[upr_pkg::MAX_DIST_W-1:0];
    endtask

    initial
    begin
        tick_word_t  w;
        int unsigned mark;
        int unsigned win;
        int          pulse;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_pings[i])
        begin
            if (directed_pings[i].cfg >= 0)
                set_max_distance(directed_pings[i].cfg);
            queue_ping(2, directed_pings[i].clear, directed_pings[i].gap,
                       directed_pings[i].pulse, 100);
            if (directed_pings[i].known != 0)
            begin
                w             = tick_q.pop_back();
                w.known       = 1'b1;
                w.exp_no_echo = (directed_pings[i].no_echo != 0);
                w.exp_time    = directed_pings[i].time_us;
                w.exp_dist    = directed_pings[i].dist_cm;
                tick_q.push_back(w);
            end
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph % 4 == 0)
                set_max_distance($urandom_range(99) < 85 ? $urandom_range(4)
                                                          : $urandom_range(511));
            else
                set_max_distance($urandom_range(4));
            case (ph % 4)
                0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1:       begin in_idle_pct = 85; out_stall_pct = 0;  end
                2:       begin in_idle_pct = 0;  out_stall_pct = 85; end
                default: begin in_idle_pct = 23; out_stall_pct = 23; end
            endcase
            win  = echo_window();
            mark = words_built;
            while (words_built - mark < 30)
            begin
                if ($urandom_range(99) < 20)
                begin
                    repeat ($urandom_range(20, 1))
                        push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                end
                else
                begin
                    if (win <= 800 && $urandom_range(99) < 25)
                        pulse = $urandom_range(win + 3, win > 2 ? win - 2 : 1);
                    else
                        pulse = $urandom_range(40, 1);
                    queue_ping($urandom_range(3),
                               $urandom_range(99) < 70 ? 0 : $urandom_range(6, 1),
                               $urandom_range(12, 1), pulse, $urandom_range(100));
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/upr_pkg.sv
rtl/core/upr_dist.sv
rtl/core/upr_seq.sv
rtl/core/ultrasonic_ping_ranger_core.sv
tb/sv/ultrasonic_ping_ranger_core_tb.sv
